>>> src/linear_least_squares_fit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the least-squares fit block
// Shorthand for clocked implications with an asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_LEAST_SQUARES_FIT_MACROS_SVH
`define LINEAR_LEAST_SQUARES_FIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LLSF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LLSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/llsf_pkg.sv
// ----------------------------------------------------------------------------
// llsf_pkg
// Types, codes and constants shared by the least-squares fit modules.
// ----------------------------------------------------------------------------
package llsf_pkg;

	localparam int WIDE_W      = 128;
	localparam int SX_W        = 20;
	localparam int SXX_W       = 36;
	localparam int SY_W        = 46;
	localparam int SXY_W       = 62;
	localparam int SYY_W       = 85;
	localparam int A_W         = 41;
	localparam int B_W         = 67;
	localparam int RATIO_NUM_W = 41;
	localparam int RATIO_SHIFT = WIDE_W - RATIO_NUM_W;

	localparam logic [7:0] MUL_STEPS   = 8'd64;
	localparam logic [7:0] SQRT_STEPS  = 8'd64;
	localparam logic [7:0] DIV_STEPS   = 8'd128;
	localparam logic [7:0] RATIO_STEPS = 8'(RATIO_NUM_W);

	localparam logic [47:0] SAT_MAX  = 48'h7FFF_FFFF_FFFF;
	localparam logic [31:0] CORR_ONE = 32'h4000_0000;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_PIXEL = 2'd1;
	localparam logic [1:0] STATUS_VAR   = 2'd2;

	typedef struct packed {
		logic [15:0] distance;
		logic [11:0] top_row;
		logic [11:0] bottom_row;
	} item_t;

	typedef struct packed {
		logic signed [47:0] slope;
		logic signed [47:0] intercept;
		logic signed [31:0] correlation;
		logic        [1:0]  status;
	} result_t;

	typedef enum logic [1:0] {
		IT_MUL,
		IT_DIV,
		IT_SQRT
	} iter_op_t;

	typedef struct packed {
		logic              start;
		iter_op_t          op;
		logic [WIDE_W-1:0] a;
		logic [WIDE_W-1:0] b;
		logic [7:0]        count;
	} iter_cmd_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_RATIO,
		OP_STORE,
		OP_CLR,
		OP_ACC,
		OP_ACC_YY,
		OP_CALC_A,
		OP_CALC_B,
		OP_MUL_SY,
		OP_CALC_C,
		OP_DIV_SLOPE,
		OP_SET_SLOPE,
		OP_MUL_SYA,
		OP_SET_T1,
		OP_MUL_BSX,
		OP_SET_NUM,
		OP_DIV_ICPT,
		OP_SET_ICPT,
		OP_MUL_CA,
		OP_SET_CA,
		OP_SQRT,
		OP_SET_R,
		OP_DIV_CORR,
		OP_SET_CORR,
		OP_CORR_ONE,
		OP_CORR_ZERO,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		logic iter_busy;
		logic d_zero;
		logic last_point;
		logic last_index;
		logic skip_fit;
		logic c_zero;
		logic r_zero;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RATIO,
		S_RATIO_W,
		S_SUM_CLR,
		S_ACC,
		S_ACC_W,
		S_CALC_A,
		S_CALC_B,
		S_SYY,
		S_SYY_W,
		S_SLOPE,
		S_SLOPE_W,
		S_MUL_SYA,
		S_MUL_SYA_W,
		S_MUL_BSX,
		S_MUL_BSX_W,
		S_ICPT,
		S_ICPT_W,
		S_CORR,
		S_CORR_W,
		S_SQRT,
		S_SQRT_W,
		S_DIVC,
		S_DIVC_W,
		S_DONE
	} ctrl_state_t;

endpackage

>>> src/llsf_iter.sv
// ----------------------------------------------------------------------------
// llsf_iter
// Shared serial unit: shift-add multiply, restoring divide, bitwise sqrt.
// ----------------------------------------------------------------------------
module llsf_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  llsf_pkg::iter_cmd_t cmd,
	output logic                busy,
	output logic [127:0]        res
);
	import llsf_pkg::*;

	logic              busy_q;
	logic [7:0]        cnt_q;
	iter_op_t          op_q;
	logic [WIDE_W-1:0] r0_q;
	logic [WIDE_W-1:0] r1_q;
	logic [WIDE_W:0]   r2_q;
	logic [WIDE_W-1:0] den_q;

	logic [WIDE_W:0]   rem_sh;
	logic              div_ge;
	logic [WIDE_W-1:0] sq_t;
	logic              sq_ge;
	logic [WIDE_W-1:0] mul_sum;

	always_comb begin
		rem_sh  = {r2_q[WIDE_W-1:0], r0_q[WIDE_W-1]};
		div_ge  = rem_sh >= {1'b0, den_q};
		sq_t    = r1_q + r2_q[WIDE_W-1:0];
		sq_ge   = r0_q >= sq_t;
		mul_sum = r2_q[WIDE_W-1:0] + r0_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 8'd1;
			if (cnt_q == 8'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q <= cmd.op;
			case (cmd.op)
				IT_MUL: begin
					r0_q <= cmd.a;
					r1_q <= cmd.b;
					r2_q <= '0;
				end
				IT_DIV: begin
					r0_q  <= cmd.a;
					r1_q  <= '0;
					r2_q  <= '0;
					den_q <= cmd.b;
				end
				IT_SQRT: begin
					r0_q <= cmd.a;
					r1_q <= '0;
					r2_q <= (WIDE_W+1)'(1) << (WIDE_W - 2);
				end
				default: begin
					r0_q <= cmd.a;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				IT_MUL: begin
					if (r1_q[0]) begin
						r2_q <= {1'b0, mul_sum};
					end
					r0_q <= r0_q << 1;
					r1_q <= r1_q >> 1;
				end
				IT_DIV: begin
					r2_q <= div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
					r1_q <= {r1_q[WIDE_W-2:0], div_ge};
					r0_q <= r0_q << 1;
				end
				IT_SQRT: begin
					if (sq_ge) begin
						r0_q <= r0_q - sq_t;
						r1_q <= (r1_q >> 1) + r2_q[WIDE_W-1:0];
					end else begin
						r1_q <= r1_q >> 1;
					end
					r2_q <= r2_q >> 2;
				end
				default: begin
					r0_q <= r0_q;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign res  = (op_q == IT_MUL) ? r2_q[WIDE_W-1:0] : r1_q;

endmodule

>>> src/llsf_dp.sv
// ----------------------------------------------------------------------------
// llsf_dp
// Point stores, sums, fit registers and result register of the fit.
// ----------------------------------------------------------------------------
module llsf_dp #(
	parameter int POINTS = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  llsf_pkg::dp_op_t     op,
	input  llsf_pkg::item_t      item,
	input  logic                 height_we,
	input  logic [15:0]          height_wdata,
	output llsf_pkg::dp_status_t status,
	output logic                 done,
	output llsf_pkg::result_t    result
);
	import llsf_pkg::*;

	localparam int IDX_W = (POINTS > 1) ? $clog2(POINTS) : 1;

	logic [15:0]              height_q;
	logic [IDX_W-1:0]         cnt_q;
	logic                     pix_q;
	logic                     done_q;
	logic [IDX_W-1:0]         idx_q;

	logic [15:0]              x_cap_q;
	logic signed [12:0]       d_q;
	logic [15:0]              x_mem [POINTS];
	logic signed [47:0]       y_mem [POINTS];
	logic [SX_W-1:0]          sx_q;
	logic [SXX_W-1:0]         sxx_q;
	logic signed [SY_W-1:0]   sy_q;
	logic signed [SXY_W-1:0]  sxy_q;
	logic [SYY_W-1:0]         syy_q;
	logic [A_W-1:0]           a_q;
	logic signed [WIDE_W-1:0] b_q;
	logic [WIDE_W-1:0]        c_q;
	logic signed [WIDE_W-1:0] t_q;
	logic [63:0]              r_q;
	logic [47:0]              slope_q;
	logic [47:0]              icpt_q;
	logic [31:0]              corr_q;
	result_t                  result_q;

	iter_cmd_t                cmd;
	logic                     iter_busy;
	logic [WIDE_W-1:0]        iter_res;

	logic [15:0]              x_rd;
	logic signed [47:0]       y_rd;
	logic [47:0]              y_mag;
	logic [31:0]              xx;
	logic signed [63:0]       xy;
	logic [SY_W-1:0]          sy_mag;
	logic                     b_neg;
	logic [WIDE_W-1:0]        b_mag;
	logic [WIDE_W-1:0]        t_mag;
	logic [A_W-1:0]           n_sxx;
	logic [A_W-1:0]           sx_sq;
	logic signed [B_W-1:0]    n_sxy;
	logic signed [B_W-1:0]    sx_sy;
	logic [WIDE_W-1:0]        n_syy;
	logic [WIDE_W-1:0]        n_a;
	logic [WIDE_W-1:0]        a_wide;
	logic [11:0]              ad;
	logic [RATIO_NUM_W-1:0]   ratio_num;
	logic [47:0]              q48;
	logic signed [47:0]       y_new;
	logic                     d_zero;
	logic                     a_zero;

	function automatic logic [47:0] sat_q24(input logic [WIDE_W-1:0] q, input logic neg);
		logic [WIDE_W-1:0] lim;
		logic [WIDE_W-1:0] v;
		lim = neg ? WIDE_W'(SAT_MAX) + WIDE_W'(1) : WIDE_W'(SAT_MAX);
		v   = (q > lim) ? lim : q;
		return neg ? 48'(-v) : v[47:0];
	endfunction

	function automatic logic [31:0] sat_corr(input logic [WIDE_W-1:0] q, input logic neg);
		logic [WIDE_W-1:0] lim;
		logic [WIDE_W-1:0] v;
		lim = WIDE_W'(CORR_ONE);
		v   = (q > lim) ? lim : q;
		return neg ? 32'(-v) : v[31:0];
	endfunction

	assign x_rd      = x_mem[idx_q];
	assign y_rd      = y_mem[idx_q];
	assign y_mag     = y_rd[47] ? 48'(-y_rd) : 48'(y_rd);
	assign xx        = 32'(x_rd) * 32'(x_rd);
	assign xy        = 64'($signed({1'b0, x_rd})) * 64'(y_rd);
	assign sy_mag    = sy_q[SY_W-1] ? SY_W'(-sy_q) : SY_W'(sy_q);
	assign b_neg     = b_q[WIDE_W-1];
	assign b_mag     = b_neg ? WIDE_W'(-b_q) : WIDE_W'(b_q);
	assign t_mag     = t_q[WIDE_W-1] ? WIDE_W'(-t_q) : WIDE_W'(t_q);
	assign n_sxx     = A_W'(sxx_q) * A_W'(POINTS);
	assign sx_sq     = A_W'(sx_q) * A_W'(sx_q);
	assign n_sxy     = B_W'(sxy_q) * $signed(B_W'(POINTS));
	assign sx_sy     = B_W'($signed({1'b0, sx_q})) * B_W'(sy_q);
	assign n_syy     = WIDE_W'(syy_q) * WIDE_W'(unsigned'(POINTS));
	assign a_wide    = WIDE_W'(a_q);
	assign n_a       = a_wide * WIDE_W'(unsigned'(POINTS));
	assign ad        = d_q[12] ? 12'(-d_q) : 12'(d_q);
	assign ratio_num = {1'b0, height_q, 24'd0} + RATIO_NUM_W'(ad >> 1);
	assign q48       = iter_res[47:0];
	assign d_zero    = (d_q == 13'sd0);
	assign a_zero    = (a_q == '0);
	assign y_new     = d_zero ? 48'sd0 : (d_q[12] ? $signed(-q48) : $signed(q48));

	// Operand select for the shared serial unit
	always_comb begin
		cmd = '0;
		case (op)
			OP_DIV_RATIO: begin
				cmd.start = 1'b1;
				cmd.op    = IT_DIV;
				cmd.a     = WIDE_W'(ratio_num) << RATIO_SHIFT;
				cmd.b     = WIDE_W'(ad);
				cmd.count = RATIO_STEPS;
			end
			OP_ACC: begin
				cmd.start = 1'b1;
				cmd.op    = IT_MUL;
				cmd.a     = WIDE_W'(y_mag);
				cmd.b     = WIDE_W'(y_mag);
				cmd.count = MUL_STEPS;
			end
			OP_MUL_SY: begin
				cmd.start = 1'b1;
				cmd.op    = IT_MUL;
				cmd.a     = WIDE_W'(sy_mag);
				cmd.b     = WIDE_W'(sy_mag);
				cmd.count = MUL_STEPS;
			end
			OP_DIV_SLOPE: begin
				cmd.start = 1'b1;
				cmd.op    = IT_DIV;
				cmd.a     = b_mag + (a_wide >> 1);
				cmd.b     = a_wide;
				cmd.count = DIV_STEPS;
			end
			OP_MUL_SYA: begin
				cmd.start = 1'b1;
				cmd.op    = IT_MUL;
				cmd.a     = WIDE_W'(sy_mag);
				cmd.b     = a_wide;
				cmd.count = MUL_STEPS;
			end
			OP_MUL_BSX: begin
				cmd.start = 1'b1;
				cmd.op    = IT_MUL;
				cmd.a     = b_mag;
				cmd.b     = WIDE_W'(sx_q);
				cmd.count = MUL_STEPS;
			end
			OP_DIV_ICPT: begin
				cmd.start = 1'b1;
				cmd.op    = IT_DIV;
				cmd.a     = t_mag + (n_a >> 1);
				cmd.b     = n_a;
				cmd.count = DIV_STEPS;
			end
			OP_MUL_CA: begin
				cmd.start = 1'b1;
				cmd.op    = IT_MUL;
				cmd.a     = c_q;
				cmd.b     = a_wide;
				cmd.count = MUL_STEPS;
			end
			OP_SQRT: begin
				cmd.start = 1'b1;
				cmd.op    = IT_SQRT;
				cmd.a     = WIDE_W'(unsigned'(t_q));
				cmd.count = SQRT_STEPS;
			end
			OP_DIV_CORR: begin
				cmd.start = 1'b1;
				cmd.op    = IT_DIV;
				cmd.a     = (b_mag << 30) + (WIDE_W'(r_q) >> 1);
				cmd.b     = WIDE_W'(r_q);
				cmd.count = DIV_STEPS;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	llsf_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.busy   (iter_busy),
		.res    (iter_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
			cnt_q    <= '0;
			pix_q    <= 1'b0;
			done_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (height_we) begin
				height_q <= height_wdata;
			end
			done_q <= (op == OP_FINISH);
			case (op)
				OP_STORE: begin
					cnt_q <= cnt_q + IDX_W'(1);
					pix_q <= pix_q | d_zero;
				end
				OP_CLR: begin
					idx_q <= '0;
				end
				OP_ACC_YY: begin
					idx_q <= idx_q + IDX_W'(1);
				end
				OP_FINISH: begin
					cnt_q <= '0;
					pix_q <= 1'b0;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				x_cap_q <= item.distance;
				d_q     <= $signed({1'b0, item.bottom_row}) - $signed({1'b0, item.top_row});
			end
			OP_STORE: begin
				x_mem[cnt_q] <= x_cap_q;
				y_mem[cnt_q] <= y_new;
			end
			OP_CLR: begin
				sx_q  <= '0;
				sxx_q <= '0;
				sy_q  <= '0;
				sxy_q <= '0;
				syy_q <= '0;
			end
			OP_ACC: begin
				sx_q  <= sx_q + SX_W'(x_rd);
				sxx_q <= sxx_q + SXX_W'(xx);
				sy_q  <= sy_q + SY_W'(y_rd);
				sxy_q <= sxy_q + SXY_W'(xy);
			end
			OP_ACC_YY: begin
				syy_q <= syy_q + SYY_W'(iter_res);
			end
			OP_CALC_A: begin
				a_q <= n_sxx - sx_sq;
			end
			OP_CALC_B: begin
				b_q <= WIDE_W'(n_sxy - sx_sy);
			end
			OP_CALC_C: begin
				c_q <= n_syy - iter_res;
			end
			OP_SET_SLOPE: begin
				slope_q <= sat_q24(iter_res, b_neg);
			end
			OP_SET_T1: begin
				t_q <= sy_q[SY_W-1] ? $signed(-iter_res) : $signed(iter_res);
			end
			OP_SET_NUM: begin
				t_q <= t_q - (b_neg ? $signed(-iter_res) : $signed(iter_res));
			end
			OP_SET_ICPT: begin
				icpt_q <= sat_q24(iter_res, t_q[WIDE_W-1]);
			end
			OP_SET_CA: begin
				t_q <= $signed(iter_res);
			end
			OP_SET_R: begin
				r_q <= iter_res[63:0];
			end
			OP_SET_CORR: begin
				corr_q <= sat_corr(iter_res, b_neg);
			end
			OP_CORR_ONE: begin
				corr_q <= CORR_ONE;
			end
			OP_CORR_ZERO: begin
				corr_q <= '0;
			end
			OP_FINISH: begin
				if (pix_q) begin
					result_q.slope       <= SAT_MAX;
					result_q.intercept   <= SAT_MAX;
					result_q.correlation <= '0;
					result_q.status      <= STATUS_PIXEL;
				end else if (a_zero) begin
					result_q.slope       <= SAT_MAX;
					result_q.intercept   <= SAT_MAX;
					result_q.correlation <= (c_q == '0) ? CORR_ONE : '0;
					result_q.status      <= STATUS_VAR;
				end else begin
					result_q.slope       <= slope_q;
					result_q.intercept   <= icpt_q;
					result_q.correlation <= corr_q;
					result_q.status      <= STATUS_OK;
				end
			end
			default: begin
				x_cap_q <= x_cap_q;
			end
		endcase
	end

	assign status.iter_busy  = iter_busy;
	assign status.d_zero     = d_zero;
	assign status.last_point = (cnt_q == IDX_W'(POINTS - 1));
	assign status.last_index = (idx_q == IDX_W'(POINTS - 1));
	assign status.skip_fit   = pix_q | a_zero;
	assign status.c_zero     = (c_q == '0);
	assign status.r_zero     = (r_q == '0);
	assign done              = done_q;
	assign result            = result_q;

endmodule

>>> src/llsf_ctrl.sv
`include "linear_least_squares_fit_macros.svh"
// ----------------------------------------------------------------------------
// llsf_ctrl
// Sequencer that steps the datapath through ratio, sums and fit.
// ----------------------------------------------------------------------------
module llsf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  llsf_pkg::dp_status_t status,
	output logic                 busy,
	output llsf_pkg::dp_op_t     op
);
	import llsf_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op      = OP_LOAD;
					state_d = S_RATIO;
				end
			end
			S_RATIO: begin
				if (status.d_zero) begin
					op      = OP_STORE;
					state_d = status.last_point ? S_SUM_CLR : S_IDLE;
				end else begin
					op      = OP_DIV_RATIO;
					state_d = S_RATIO_W;
				end
			end
			S_RATIO_W: begin
				if (!status.iter_busy) begin
					op      = OP_STORE;
					state_d = status.last_point ? S_SUM_CLR : S_IDLE;
				end
			end
			S_SUM_CLR: begin
				op      = OP_CLR;
				state_d = S_ACC;
			end
			S_ACC: begin
				op      = OP_ACC;
				state_d = S_ACC_W;
			end
			S_ACC_W: begin
				if (!status.iter_busy) begin
					op      = OP_ACC_YY;
					state_d = status.last_index ? S_CALC_A : S_ACC;
				end
			end
			S_CALC_A: begin
				op      = OP_CALC_A;
				state_d = S_CALC_B;
			end
			S_CALC_B: begin
				op      = OP_CALC_B;
				state_d = S_SYY;
			end
			S_SYY: begin
				op      = OP_MUL_SY;
				state_d = S_SYY_W;
			end
			S_SYY_W: begin
				if (!status.iter_busy) begin
					op      = OP_CALC_C;
					state_d = S_SLOPE;
				end
			end
			S_SLOPE: begin
				if (status.skip_fit) begin
					state_d = S_DONE;
				end else begin
					op      = OP_DIV_SLOPE;
					state_d = S_SLOPE_W;
				end
			end
			S_SLOPE_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_SLOPE;
					state_d = S_MUL_SYA;
				end
			end
			S_MUL_SYA: begin
				op      = OP_MUL_SYA;
				state_d = S_MUL_SYA_W;
			end
			S_MUL_SYA_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_T1;
					state_d = S_MUL_BSX;
				end
			end
			S_MUL_BSX: begin
				op      = OP_MUL_BSX;
				state_d = S_MUL_BSX_W;
			end
			S_MUL_BSX_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_NUM;
					state_d = S_ICPT;
				end
			end
			S_ICPT: begin
				op      = OP_DIV_ICPT;
				state_d = S_ICPT_W;
			end
			S_ICPT_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_ICPT;
					state_d = S_CORR;
				end
			end
			S_CORR: begin
				if (status.c_zero) begin
					op      = OP_CORR_ONE;
					state_d = S_DONE;
				end else begin
					op      = OP_MUL_CA;
					state_d = S_CORR_W;
				end
			end
			S_CORR_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_CA;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				op      = OP_SQRT;
				state_d = S_SQRT_W;
			end
			S_SQRT_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_R;
					state_d = S_DIVC;
				end
			end
			S_DIVC: begin
				if (status.r_zero) begin
					op      = OP_CORR_ZERO;
					state_d = S_DONE;
				end else begin
					op      = OP_DIV_CORR;
					state_d = S_DIVC_W;
				end
			end
			S_DIVC_W: begin
				if (!status.iter_busy) begin
					op      = OP_SET_CORR;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				op      = OP_FINISH;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`LLSF_ASSERT_NEXT(a_start_taken, clk, arst_n, state_q == S_IDLE && start, state_q == S_RATIO, "start while idle did not begin a transfer")
	`LLSF_ASSERT_NEXT(a_done_returns, clk, arst_n, state_q == S_DONE, state_q == S_IDLE, "result cycle did not return to idle")
	`LLSF_ASSERT_SAME(a_iter_quiet, clk, arst_n, state_q == S_IDLE || state_q == S_DONE, !status.iter_busy, "serial unit still running outside the fit")

endmodule

>>> src/linear_least_squares_fit.sv
// ----------------------------------------------------------------------------
// linear_least_squares_fit
// Calibration fit: per-point ratio, then slope, intercept and correlation.
// ----------------------------------------------------------------------------
// Each point runs from its transfer through the 41-step ratio division, which
// is skipped with zero pixel height; the last point of a set then runs the fit
// in the shared serial unit (64-step multiply and sqrt, 128-step divide).
// busy stays high until the point or the fit ends, so no new point is taken before.
// The result shows for one cycle with done high; the receiver cannot stall.
// Reset clears the point count, pixel flag and object_height; stores need none.
// ----------------------------------------------------------------------------
module linear_least_squares_fit #(
	parameter int POINTS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  llsf_pkg::item_t   item,
	output logic              busy,
	output logic              done,
	output llsf_pkg::result_t result,
	input  logic              object_height_we,
	input  logic [15:0]       object_height
);
	import llsf_pkg::*;

	dp_op_t     op;
	dp_status_t status;

	// Sequence the fit: one datapath operation per cycle, hold while the
	// serial unit runs.
	llsf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.busy   (busy),
		.op     (op)
	);

	// Hold the point stores and sums; the item is captured on the transfer.
	llsf_dp #(
		.POINTS (POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.item         (item),
		.height_we    (object_height_we),
		.height_wdata (object_height),
		.status       (status),
		.done         (done),
		.result       (result)
	);

endmodule

>>> bench/linear_least_squares_fit_tb.sv
// ----------------------------------------------------------------------------
// linear_least_squares_fit_tb
// Feeds calibration points to the fit block and checks every fit result.
// A directed table covers the extreme fields and each corner case: zero pixel
// height, zero distance variance and zero ratio variance. Random sets follow.
// Expected fits come from a bit-exact fixed-point model held in the bench.
// ----------------------------------------------------------------------------
module linear_least_squares_fit_tb;
	import llsf_pkg::*;

	localparam int NPTS       = 5;
	localparam int HALF_CYCLE = 6;
	localparam int SETTLE     = 60;    // quiet cycles before a height write
	localparam int STALL_MAX  = 5000;  // longest legal run with no transfer
	localparam int RAND_SETS  = 100;

	typedef struct {
		bit          height_we;
		logic [15:0] height;
		item_t       pt;
		bit          typed;     // expectation typed in rather than predicted
		result_t     fit;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	item_t       item = '0;
	logic        busy;
	logic        done;
	result_t     result;
	logic        object_height_we = 1'b0;
	logic [15:0] object_height = '0;

	// Bench copy of the block state
	logic [15:0]        model_height = '0;
	logic [15:0]        dist_mem [NPTS];
	logic signed [47:0] ratio_mem [NPTS];
	int                 pts_held = 0;
	bit                 pix_flag = 1'b0;

	result_t pending_fits [$];
	row_t    rows [$];
	int      errors = 0;
	int      quiet_cycles = 0;
	int      burst_left = 0;

	linear_least_squares_fit #(.POINTS(NPTS)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.item            (item),
		.busy            (busy),
		.done            (done),
		.result          (result),
		.object_height_we(object_height_we),
		.object_height   (object_height)
	);

	always #HALF_CYCLE clk = ~clk;

	// Round num/den to nearest, ties away from zero, and clamp the magnitude.
	function automatic logic signed [255:0] round_div(input logic signed [255:0] num,
			input logic signed [255:0] den, input logic signed [255:0] lim_pos,
			input logic signed [255:0] lim_neg);
		logic signed [255:0] mag;
		logic signed [255:0] q;
		mag = (num < 0) ? -num : num;
		q = (mag + (den >>> 1)) / den;
		if (num < 0) begin
			return (q > lim_neg) ? -lim_neg : -q;
		end
		return (q > lim_pos) ? lim_pos : q;
	endfunction

	function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
		logic [255:0] root;
		logic [255:0] trial;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			trial = root | (256'd1 << i);
			if (trial * trial <= {128'd0, v}) begin
				root = trial;
			end
		end
		return root[127:0];
	endfunction

	// Take one point into the bench state; return 1 with the fit when the set
	// is complete.
	function automatic bit fit_point(input item_t pt, output result_t fit);
		logic signed [255:0] d, ad, y, sx, sxx, sy, sxy, syy, a, b, c, num, lim;
		logic [127:0] ca;
		logic [127:0] root;
		d = $signed({1'b0, pt.bottom_row}) - $signed({1'b0, pt.top_row});
		y = 0;
		if (d == 0) begin
			pix_flag = 1'b1;
		end else begin
			ad = (d < 0) ? -d : d;
			y = (($signed({1'b0, model_height}) <<< 24) + (ad >>> 1)) / ad;
			if (d < 0) begin
				y = -y;
			end
		end
		dist_mem[pts_held] = pt.distance;
		ratio_mem[pts_held] = y[47:0];
		pts_held++;
		fit = '0;
		if (pts_held < NPTS) begin
			return 1'b0;
		end
		sx = 0; sxx = 0; sy = 0; sxy = 0; syy = 0;
		for (int i = 0; i < NPTS; i++) begin
			sx += $signed({1'b0, dist_mem[i]});
			sxx += $signed({1'b0, dist_mem[i]}) * $signed({1'b0, dist_mem[i]});
			sy += ratio_mem[i];
			sxy += $signed({1'b0, dist_mem[i]}) * ratio_mem[i];
			syy += ratio_mem[i] * ratio_mem[i];
		end
		a = NPTS * sxx - sx * sx;
		b = NPTS * sxy - sx * sy;
		c = NPTS * syy - sy * sy;
		lim = 256'sd1 <<< 47;
		if (pix_flag) begin
			fit = '{SAT_MAX, SAT_MAX, 32'd0, STATUS_PIXEL};
		end else if (a == 0) begin
			fit = '{SAT_MAX, SAT_MAX, (c == 0) ? CORR_ONE : 32'd0, STATUS_VAR};
		end else begin
			fit.status = STATUS_OK;
			fit.slope = 48'(round_div(b, a, lim - 1, lim));
			num = sy * a - b * sx;
			fit.intercept = 48'(round_div(num, NPTS * a, lim - 1, lim));
			if (c == 0) begin
				fit.correlation = CORR_ONE;
			end else begin
				// the product wraps at 128 bits, as the block's datapath does
				ca = c[127:0] * a[127:0];
				root = floor_sqrt(ca);
				fit.correlation = (root == 0) ? 32'd0 :
					32'(round_div(b <<< 30, $signed({128'd0, root}), 256'sd1 <<< 30,
						256'sd1 <<< 30));
			end
		end
		pts_held = 0;
		pix_flag = 1'b0;
		return 1'b1;
	endfunction

	task automatic report(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on %s: got %h, expected %h", field, got, want);
		errors++;
	endtask

	// Drop start and hold off before the next transfer.
	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold the point on the port until the block takes it; leave start high so
	// a back-to-back transfer needs no second assignment.
	task automatic send_point(input item_t pt, input bit typed, input result_t typed_fit);
		result_t fit;
		if (burst_left == 0) begin
			pause($urandom_range(0, 15));
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		start <= 1'b1;
		item <= pt;
		do @(posedge clk); while (busy);
		if (fit_point(pt, fit)) begin
			pending_fits.push_back(typed ? typed_fit : fit);
		end
	endtask

	// Write the height only with the block idle and nothing in flight.
	task automatic write_height(input logic [15:0] h);
		pause(1);
		while (busy || pending_fits.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		object_height_we <= 1'b1;
		object_height <= h;
		@(posedge clk);
		model_height = h;
		object_height_we <= 1'b0;
	endtask

	task automatic add_row(input bit we, input logic [15:0] h, input logic [15:0] x_dist,
			input logic [11:0] top, input logic [11:0] bot, input bit typed,
			input result_t fit);
		row_t r;
		r.height_we = we;
		r.height = h;
		r.pt = '{x_dist, top, bot};
		r.typed = typed;
		r.fit = fit;
		rows.push_back(r);
	endtask

	// Compare each fit with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_fits.size() == 0) begin
				$display("unexpected fit result %h", result);
				errors++;
			end else begin
				result_t want;
				want = pending_fits.pop_front();
				if (result.slope !== want.slope)
					report("slope", 64'(result.slope), 64'(want.slope));
				if (result.intercept !== want.intercept)
					report("intercept", 64'(result.intercept), 64'(want.intercept));
				if (result.correlation !== want.correlation)
					report("correlation", 64'(result.correlation), 64'(want.correlation));
				if (result.status !== want.status)
					report("status", 64'(result.status), 64'(want.status));
			end
		end
	end

	// Advance the stall counter on every cycle with no transfer at all.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || object_height_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_MAX) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		result_t none;
		logic [15:0] h;
		logic [15:0] x_dist;
		logic [11:0] top;
		bit flat;
		none = '0;

		// Height zero after reset: every ratio is 0, so correlation is forced to one.
		add_row(0, 0, 16'd0, 12'd0, 12'd1, 0, none);
		add_row(0, 0, 16'hFFFF, 12'hFFF, 12'd0, 0, none);
		add_row(0, 0, 16'd100, 12'd0, 12'hFFF, 0, none);
		add_row(0, 0, 16'd200, 12'd7, 12'd9, 0, none);
		add_row(0, 0, 16'd300, 12'd9, 12'd7, 1, '{48'sd0, 48'sd0, CORR_ONE, STATUS_OK});
		// Zero pixel height anywhere in the set saturates the fit.
		add_row(1, 16'hFFFF, 16'd10, 12'd0, 12'd1, 0, none);
		add_row(0, 0, 16'd20, 12'd55, 12'd55, 0, none);
		add_row(0, 0, 16'd30, 12'hFFF, 12'd0, 0, none);
		add_row(0, 0, 16'd40, 12'd0, 12'hFFF, 0, none);
		add_row(0, 0, 16'd50, 12'd3, 12'd1, 1, '{SAT_MAX, SAT_MAX, 32'd0, STATUS_PIXEL});
		// Equal distances, varied ratios: no distance variance.
		add_row(1, 16'd1000, 16'd500, 12'd0, 12'd1, 0, none);
		add_row(0, 0, 16'd500, 12'd0, 12'd2, 0, none);
		add_row(0, 0, 16'd500, 12'd0, 12'd3, 0, none);
		add_row(0, 0, 16'd500, 12'd5, 12'd0, 0, none);
		add_row(0, 0, 16'd500, 12'd0, 12'd9, 1, '{SAT_MAX, SAT_MAX, 32'd0, STATUS_VAR});
		// Equal distances and equal ratios.
		add_row(1, 16'hFFFF, 16'hFFFF, 12'd1, 12'd4, 0, none);
		add_row(0, 0, 16'hFFFF, 12'd1, 12'd4, 0, none);
		add_row(0, 0, 16'hFFFF, 12'd1, 12'd4, 0, none);
		add_row(0, 0, 16'hFFFF, 12'd1, 12'd4, 0, none);
		add_row(0, 0, 16'hFFFF, 12'd1, 12'd4, 1, '{SAT_MAX, SAT_MAX, CORR_ONE, STATUS_VAR});
		// General fit with the largest and negative ratios.
		add_row(0, 0, 16'd0, 12'd0, 12'd1, 0, none);
		add_row(0, 0, 16'hFFFF, 12'hFFF, 12'hFFE, 0, none);
		add_row(0, 0, 16'd1234, 12'd100, 12'd700, 0, none);
		add_row(0, 0, 16'd40000, 12'd700, 12'd100, 0, none);
		add_row(0, 0, 16'd7, 12'd0, 12'hFFF, 0, none);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].height_we) begin
				write_height(rows[i].height);
			end
			send_point(rows[i].pt, rows[i].typed, rows[i].fit);
		end

		// Random sets; now and then a new height between sets, extremes among them.
		for (int s = 0; s < RAND_SETS; s++) begin
			if ($urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0: h = 16'd0;
					1: h = 16'hFFFF;
					default: h = 16'($urandom());
				endcase
				write_height(h);
			end
			flat = ($urandom_range(0, 9) == 0);
			x_dist = 16'($urandom());
			for (int p = 0; p < NPTS; p++) begin
				top = 12'($urandom());
				send_point('{flat ? x_dist : 16'($urandom()), top,
					($urandom_range(0, 19) == 0) ? top : 12'($urandom())}, 0, none);
			end
		end

		pause(1);
		while (pending_fits.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_fits.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
